// ----- design/csbp_pkg.sv -----
// ----------------------------------------------------------------------------
// csbp_pkg
// Shared constants for the code and symbol bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package csbp_pkg;

  // widths of the transaction fields
  localparam int unsigned FieldCodeBits = 16;
  localparam int unsigned LengthBits    = 5;
  localparam int unsigned ByteBits      = 8;
  localparam int unsigned PendingBits   = 7;
  localparam int unsigned CountBits     = 3;

  // accumulator holds pending bits, the longest code and one symbol
  localparam int unsigned AccBits       = PendingBits + FieldCodeBits + ByteBits;
  // up to three completed bytes per pack transaction
  localparam int unsigned MaxBytes      = 3;
  localparam int unsigned WordBits      = MaxBytes * ByteBits;
  localparam int unsigned ByteCountBits = 2;

  // default code width cap
  localparam int unsigned CODE_WIDTH_DEFAULT = 16;

  // operation codes
  localparam logic OP_PACK  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

endpackage

`default_nettype wire

// ----- design/csbp_if.sv -----
// ----------------------------------------------------------------------------
// csbp_if
// Valid/ready channels for packer input items and output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

// input channel: one pack or flush request per transaction
interface csbp_item_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] code_value;
  logic [4:0]  code_length;
  logic [7:0]  symbol_byte;

  modport source (output valid, output operation, output code_value,
                  output code_length, output symbol_byte, input ready);
  modport sink   (input valid, input operation, input code_value,
                  input code_length, input symbol_byte, output ready);
endinterface

// output channel: one packed byte per transaction
interface csbp_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       last_of_run;

  modport source (output valid, output packed_byte, output last_of_run, input ready);
  modport sink   (input valid, input packed_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- design/code_symbol_bit_packer.sv -----
// ----------------------------------------------------------------------------
// code_symbol_bit_packer
// Packs code and symbol pairs into bytes, least significant bit first.
// ----------------------------------------------------------------------------
// Usage:
//   item   : pack (code of 0..16 bits plus an 8-bit symbol) or flush requests.
//   result : one packed byte per transaction, earliest bit in bit 0;
//            last_of_run marks the final byte caused by an item.
// A pack item yields 1 to 3 bytes, a flush yields the partial byte with its
// unused high bits zero, or nothing when no bits are pending.
// Latency: the first byte of an item is valid the cycle after it is taken.
// Throughput: the byte buffer hands out one byte per cycle while the receiver
// is ready; a flush with nothing pending leaves the buffer empty;
// the next item is taken in the cycle its predecessor's last byte leaves.
// Reset (rst, synchronous) empties the byte buffer and the pending bits.
// When the receiver stalls, the current byte holds and item.ready drops
// once the buffer cannot be emptied in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module code_symbol_bit_packer
  import csbp_pkg::*;
#(
  parameter int unsigned CODE_WIDTH = CODE_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  csbp_item_if.sink     item,
  csbp_result_if.source result
);

  // effective code length cap
  localparam int unsigned CodeCap = (CODE_WIDTH < FieldCodeBits) ? CODE_WIDTH : FieldCodeBits;
  localparam logic [LengthBits-1:0] LenCap = LengthBits'(CodeCap);

  // state
  logic [PendingBits-1:0]   pending_bits;
  logic [CountBits-1:0]     pending_count;
  logic [WordBits-1:0]      byte_word;
  logic [ByteCountBits-1:0] byte_count;

  // combinational
  logic                     take;
  logic                     emit;
  logic [LengthBits-1:0]    eff_len;
  logic [FieldCodeBits-1:0] code_masked;
  logic [AccBits-1:0]       acc;
  logic [LengthBits-1:0]    total;
  logic [ByteCountBits-1:0] pack_bytes;
  logic [AccBits-1:0]       acc_rest;
  logic [WordBits-1:0]      load_word;
  logic [ByteCountBits-1:0] load_count;
  logic [PendingBits-1:0]   pending_bits_next;
  logic [CountBits-1:0]     pending_count_next;

  // handshakes
  assign emit       = result.valid && result.ready;
  assign item.ready = (byte_count == '0) || ((byte_count == ByteCountBits'(1)) && result.ready);
  assign take       = item.valid && item.ready;

  // output register view of the byte buffer
  assign result.valid       = (byte_count != '0);
  assign result.packed_byte = byte_word[ByteBits-1:0];
  assign result.last_of_run = (byte_count == ByteCountBits'(1));

  // append code and symbol to the pending bits
  always_comb begin
    eff_len     = (item.code_length > LenCap) ? LenCap : item.code_length;
    code_masked = item.code_value & ~({FieldCodeBits{1'b1}} << eff_len);
    acc         = AccBits'(pending_bits)
                | (AccBits'(code_masked) << pending_count)
                | (AccBits'(item.symbol_byte) << (LengthBits'(pending_count) + eff_len));
    total       = LengthBits'(pending_count) + eff_len + LengthBits'(ByteBits);
    pack_bytes  = total[LengthBits-1:CountBits];
    acc_rest    = acc >> {pack_bytes, 3'b000};
  end

  // select what an accepted transaction loads
  always_comb begin
    unique case (item.operation)
      OP_FLUSH: begin
        load_word          = WordBits'(pending_bits);
        load_count         = (pending_count != '0) ? ByteCountBits'(1) : '0;
        pending_bits_next  = '0;
        pending_count_next = '0;
      end
      default: begin
        load_word          = acc[WordBits-1:0];
        load_count         = pack_bytes;
        pending_bits_next  = acc_rest[PendingBits-1:0];
        pending_count_next = total[CountBits-1:0];
      end
    endcase
  end

  // byte buffer and pending store
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      if (take) begin
        byte_word     <= load_word;
        byte_count    <= load_count;
        pending_bits  <= pending_bits_next;
        pending_count <= pending_count_next;
      end else if (emit) begin
        byte_word  <= byte_word >> ByteBits;
        byte_count <= byte_count - ByteCountBits'(1);
      end
    end
  end

  // bits above the pending count stay zero
  a_pending_clean: assert property (@(posedge clk) disable iff (rst)
    ((pending_bits >> pending_count) == '0))
    else $error("pending bits set above pending count");

  // a pack transaction always produces at least one byte
  a_pack_emits: assert property (@(posedge clk) disable iff (rst)
    (take && (item.operation == OP_PACK)) |=> result.valid)
    else $error("pack transaction produced no byte");

  // a flush leaves nothing pending
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (take && (item.operation == OP_FLUSH)) |=> (pending_count == '0))
    else $error("flush left pending bits");

  // a new item is taken only when the buffer is empty or drains this cycle
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    take |-> ((byte_count == '0) || ((byte_count == ByteCountBits'(1)) && emit)))
    else $error("item taken over undelivered bytes");

endmodule

`default_nettype wire

// ----- tb/tb_code_symbol_bit_packer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_code_symbol_bit_packer
// Self-checking bench for the code and symbol bit packer. Pack and flush
// requests go in over the item channel; a software bit accumulator predicts
// every output byte and its end-of-item flag, and each byte taken from the
// result channel is checked in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_code_symbol_bit_packer;
  import csbp_pkg::*;

  // one predicted output byte
  typedef struct packed {
    logic [ByteBits-1:0] packed_byte;
    logic                last_of_run;
  } packed_byte_t;

  // bit accumulator that predicts the packed byte stream
  class packed_stream_scoreboard;
    logic [PendingBits-1:0] pend_bits;
    logic [CountBits-1:0]   pend_count;
    packed_byte_t           expected_bytes[$];
    int unsigned            failures;
    int unsigned            code_cap;

    function new(int unsigned code_width);
      pend_bits  = '0;
      pend_count = '0;
      failures   = 0;
      code_cap   = (code_width < FieldCodeBits) ? code_width : FieldCodeBits;
    endfunction

    // work out the bytes caused by one accepted transaction
    function void take_item(logic op, logic [15:0] code, logic [4:0] len,
                            logic [7:0] sym);
      int unsigned  eff_len;
      int unsigned  total;
      logic [31:0]  code_bits;
      logic [31:0]  acc;
      packed_byte_t nb;
      if (op == OP_FLUSH) begin
        // partial byte with zero high bits, nothing when empty
        if (pend_count != 0) begin
          nb.packed_byte = {1'b0, pend_bits};
          nb.last_of_run = 1'b1;
          expected_bytes.push_back(nb);
          pend_bits  = '0;
          pend_count = '0;
        end
        return;
      end
      // long codes saturate at the code width
      eff_len = len;
      if (eff_len > code_cap) eff_len = code_cap;
      code_bits = 32'(code) & ((32'h1 << eff_len) - 32'h1);
      acc = 32'(pend_bits) | (code_bits << pend_count)
            | (32'(sym) << (pend_count + eff_len));
      total = pend_count + eff_len + ByteBits;
      while (total >= ByteBits) begin
        nb.packed_byte = acc[7:0];
        nb.last_of_run = (total < 2 * ByteBits);
        expected_bytes.push_back(nb);
        acc   = acc >> ByteBits;
        total = total - ByteBits;
      end
      pend_count = total[CountBits-1:0];
      pend_bits  = acc[PendingBits-1:0];
    endfunction

    // compare one accepted byte with the oldest prediction
    function void check_byte(logic [7:0] got_byte, logic got_last);
      packed_byte_t exp_b;
      if (expected_bytes.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: byte %02h last %0b arrived with nothing expected",
                   $time, got_byte, got_last);
        return;
      end
      exp_b = expected_bytes.pop_front();
      if (got_byte !== exp_b.packed_byte || got_last !== exp_b.last_of_run) begin
        failures++;
        if (failures <= 10)
          $display("%0t: byte mismatch, expected %02h last %0b, got %02h last %0b",
                   $time, exp_b.packed_byte, exp_b.last_of_run, got_byte, got_last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  packed_stream_scoreboard byte_board;

  csbp_item_if   item_if();
  csbp_result_if result_if();

  code_symbol_bit_packer #(
    .CODE_WIDTH(CODE_WIDTH_DEFAULT)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .item  (item_if),
    .result(result_if)
  );

  // 10 ns clock
  always #5 clk = ~clk;

  // receiver stalls at random
  always @(negedge clk) begin
    result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // check every byte that leaves the block
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready)
      byte_board.check_byte(result_if.packed_byte, result_if.last_of_run);
  end

  // run limit
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // drive one transaction, called and returning at a falling edge
  task automatic send_item(logic op, logic [15:0] code, logic [4:0] len,
                           logic [7:0] sym);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk);
    end
    item_if.valid       <= 1'b1;
    item_if.operation   <= op;
    item_if.code_value  <= code;
    item_if.code_length <= len;
    item_if.symbol_byte <= sym;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    byte_board.take_item(op, code, len, sym);
    @(negedge clk);
  endtask

  // random transaction, mostly packs with in-range lengths
  task automatic send_random_item();
    int unsigned pick;
    logic [4:0]  len;
    pick = $urandom_range(99);
    if (pick < 80)      len = 5'($urandom_range(16, 1));
    else if (pick < 88) len = 5'd0;
    else                len = 5'($urandom_range(31, 17));
    send_item(($urandom_range(99) < 15) ? OP_FLUSH : OP_PACK,
              16'($urandom), len, 8'($urandom));
  endtask

  // hold the sender until every predicted byte is out
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    @(negedge clk);
    while (byte_board.expected_bytes.size() != 0) @(negedge clk);
  endtask

  initial begin
    clk                   = 1'b0;
    rst                   = 1'b1;
    item_if.valid         = 1'b0;
    item_if.operation     = OP_PACK;
    item_if.code_value    = '0;
    item_if.code_length   = '0;
    item_if.symbol_byte   = '0;
    result_if.ready       = 1'b0;
    send_idle_pct         = 21;
    recv_stall_pct        = 82;
    byte_board            = new(CODE_WIDTH_DEFAULT);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty flush, extreme codes and symbols, three-byte items,
    // zero and oversize lengths, flush fields ignored
    send_item(OP_FLUSH, 16'($urandom), 5'($urandom), 8'($urandom));
    send_item(OP_PACK, 16'h0000, 5'd1, 8'h00);
    send_item(OP_PACK, 16'hffff, 5'd16, 8'hff);
    send_item(OP_FLUSH, 16'($urandom), 5'($urandom), 8'($urandom));
    send_item(OP_FLUSH, 16'($urandom), 5'($urandom), 8'($urandom));
    send_item(OP_PACK, 16'h0055, 5'd7, 8'ha5);
    send_item(OP_PACK, 16'hffff, 5'd16, 8'h00);
    send_item(OP_PACK, 16'h1234, 5'd0, 8'hff);
    send_item(OP_PACK, 16'hffff, 5'd31, 8'h3c);
    send_item(OP_PACK, 16'ha5a5, 5'd17, 8'hc3);
    send_item(OP_PACK, 16'h8001, 5'd8, 8'h81);
    send_item(OP_FLUSH, 16'hffff, 5'd31, 8'hff);
    send_item(OP_PACK, 16'hffff, 5'd1, 8'hff);
    send_item(OP_FLUSH, 16'h0000, 5'd0, 8'h00);
    send_item(OP_PACK, 16'h0000, 5'd16, 8'h00);
    send_item(OP_FLUSH, 16'($urandom), 5'($urandom), 8'($urandom));
    wait_drained();

    // random: slow receiver, then slow sender, then full rate
    repeat (150) send_random_item();
    wait_drained();
    send_idle_pct  = 82;
    recv_stall_pct = 21;
    repeat (150) send_random_item();
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (150) send_random_item();

    // drain and let the block settle
    wait_drained();
    repeat (8) @(negedge clk);
    if (byte_board.failures == 0 && byte_board.expected_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
